// ----- rtl/mqfb_pkg.sv -----
// Package with sizes, codes and the controller command type for the queue bank.
`timescale 1ns / 1ps
`default_nettype none
package mqfb_pkg;

    localparam int NUM_QUEUES  = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int WORD_WIDTH  = 32;

    localparam int OP_W     = 2;
    localparam int QIN_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LOST_W   = 32;

    localparam int STORE_W = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
    localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    localparam logic [DATA_W-1:0] BAD_INDEX_WORD = 32'h7FFF_FFFF;
    localparam logic [LOST_W-1:0] LOST_MAX       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl_cmd;

endpackage
`default_nettype wire

// ----- rtl/mqfb_ctrl.sv -----
// Controller state machine that sequences request capture, execution and response.
`timescale 1ns / 1ps
`default_nettype none
module mqfb_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    output mqfb_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_s_tready;
    logic   r_m_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s_tready <= 1'b1;
            r_m_tvalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state    <= S_EXEC;
                        r_s_tready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state    <= S_RESP;
                    r_m_tvalid <= 1'b1;
                end
                S_RESP: begin
                    if (i_m_tready) begin
                        r_state    <= S_IDLE;
                        r_m_tvalid <= 1'b0;
                        r_s_tready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_s_tready <= 1'b1;
                    r_m_tvalid <= 1'b0;
                end
            endcase
        end
    end

    assign o_s_tready = r_s_tready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_cmd.load = i_s_tvalid && r_s_tready;
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule
`default_nettype wire

// ----- rtl/mqfb_datapath.sv -----
// Datapath with per-queue pointers, occupancy, lost counters and the word store.
`timescale 1ns / 1ps
`default_nettype none
module mqfb_datapath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  mqfb_pkg::t_ctrl_cmd                i_cmd,
    input  wire  [mqfb_pkg::OP_W-1:0]          i_opcode,
    input  wire  [mqfb_pkg::QIN_W-1:0]         i_queue_index,
    input  wire  [mqfb_pkg::DATA_W-1:0]        i_write_word,
    output logic [mqfb_pkg::DATA_W-1:0]        o_read_word,
    output logic [mqfb_pkg::STATUS_W-1:0]      o_status,
    output logic [mqfb_pkg::LOST_W-1:0]        o_lost_words
);

    logic [mqfb_pkg::OP_W-1:0]     r_op;
    logic [mqfb_pkg::QIN_W-1:0]    r_q;
    logic [mqfb_pkg::STORE_W-1:0]  r_wdata;

    logic [mqfb_pkg::PTR_W-1:0]    r_rp   [mqfb_pkg::NUM_QUEUES];
    logic [mqfb_pkg::PTR_W-1:0]    r_wp   [mqfb_pkg::NUM_QUEUES];
    logic [mqfb_pkg::OCC_W-1:0]    r_occ  [mqfb_pkg::NUM_QUEUES];
    logic [mqfb_pkg::LOST_W-1:0]   r_lost [mqfb_pkg::NUM_QUEUES];

    logic [mqfb_pkg::STORE_W-1:0]  r_mem [mqfb_pkg::MEM_DEPTH];
    logic [mqfb_pkg::STORE_W-1:0]  r_mem_q;

    logic [mqfb_pkg::STATUS_W-1:0] r_status;
    logic [mqfb_pkg::LOST_W-1:0]   r_lost_out;
    logic                          r_rd_ok;
    logic                          r_bad_read;

    logic                          bad;
    logic [mqfb_pkg::QIDX_W-1:0]   qi;
    logic [mqfb_pkg::PTR_W-1:0]    cur_rp;
    logic [mqfb_pkg::PTR_W-1:0]    cur_wp;
    logic [mqfb_pkg::OCC_W-1:0]    cur_occ;
    logic [mqfb_pkg::LOST_W-1:0]   cur_lost;
    logic [mqfb_pkg::PTR_W-1:0]    n_rp;
    logic [mqfb_pkg::PTR_W-1:0]    n_wp;
    logic [mqfb_pkg::OCC_W-1:0]    n_occ;
    logic [mqfb_pkg::LOST_W-1:0]   n_lost;
    logic [mqfb_pkg::STATUS_W-1:0] n_status;
    logic                          n_rd_ok;
    logic                          mem_we;
    logic                          mem_re;
    logic [mqfb_pkg::ADDR_W-1:0]   mem_addr;

    function automatic logic [mqfb_pkg::PTR_W-1:0] advance(
        input logic [mqfb_pkg::PTR_W-1:0] p
    );
        if (int'(p) == mqfb_pkg::QUEUE_DEPTH - 1) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign bad      = (int'(r_q) >= mqfb_pkg::NUM_QUEUES);
    assign qi       = r_q[mqfb_pkg::QIDX_W-1:0];
    assign cur_rp   = r_rp[qi];
    assign cur_wp   = r_wp[qi];
    assign cur_occ  = r_occ[qi];
    assign cur_lost = r_lost[qi];

    always_comb begin
        n_rp     = cur_rp;
        n_wp     = cur_wp;
        n_occ    = cur_occ;
        n_lost   = cur_lost;
        n_status = mqfb_pkg::ST_OK;
        n_rd_ok  = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = mqfb_pkg::ADDR_W'(int'(qi) * mqfb_pkg::QUEUE_DEPTH + int'(cur_rp));
        if (bad) begin
            n_status = mqfb_pkg::ST_BAD_INDEX;
        end else begin
            case (r_op)
                mqfb_pkg::OP_CLEAR: begin
                    n_rp   = '0;
                    n_wp   = '0;
                    n_occ  = '0;
                    n_lost = '0;
                end
                mqfb_pkg::OP_READ: begin
                    if (cur_occ == '0) begin
                        n_status = mqfb_pkg::ST_EMPTY;
                    end else begin
                        mem_re  = i_cmd.exec;
                        n_rd_ok = 1'b1;
                        n_rp    = advance(cur_rp);
                        n_occ   = cur_occ - 1'b1;
                    end
                end
                mqfb_pkg::OP_WRITE: begin
                    mem_addr = mqfb_pkg::ADDR_W'(int'(qi) * mqfb_pkg::QUEUE_DEPTH
                                                 + int'(cur_wp));
                    if (int'(cur_occ) >= mqfb_pkg::QUEUE_DEPTH) begin
                        n_status = mqfb_pkg::ST_FULL;
                        if (cur_lost != mqfb_pkg::LOST_MAX) begin
                            n_lost = cur_lost + 1'b1;
                        end
                    end else begin
                        mem_we = i_cmd.exec;
                        n_wp   = advance(cur_wp);
                        n_occ  = cur_occ + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_q     <= i_queue_index;
            r_wdata <= i_write_word[mqfb_pkg::STORE_W-1:0];
        end
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_lost_out <= bad ? '0 : n_lost;
            r_rd_ok    <= n_rd_ok;
            r_bad_read <= bad && (r_op == mqfb_pkg::OP_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mqfb_pkg::NUM_QUEUES; k++) begin
                r_rp[k]   <= '0;
                r_wp[k]   <= '0;
                r_occ[k]  <= '0;
                r_lost[k] <= '0;
            end
        end else if (i_cmd.exec && !bad) begin
            r_rp[qi]   <= n_rp;
            r_wp[qi]   <= n_wp;
            r_occ[qi]  <= n_occ;
            r_lost[qi] <= n_lost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_addr];
        end
    end

    always_comb begin
        if (r_rd_ok) begin
            o_read_word = mqfb_pkg::DATA_W'(r_mem_q);
        end else if (r_bad_read) begin
            o_read_word = mqfb_pkg::BAD_INDEX_WORD;
        end else begin
            o_read_word = '0;
        end
    end

    assign o_status     = r_status;
    assign o_lost_words = r_lost_out;

endmodule
`default_nettype wire

// ----- rtl/multi_queue_fifo_bank.sv -----
// Top level of the multi-queue circular FIFO bank.
//
// Requests arrive on the slave stream. tuser carries the opcode (clear, read,
// write) and the queue index, and tdata carries the word for a write. Every
// request produces exactly one response on the master stream, where tdata
// carries the read word and the queue's lost-word count and tuser the status.
// A request accepted in the idle state passes through the execute state
// before its response is made valid. The block works on one request at a
// time: it takes a request, executes it against the pointer tables and the
// word store, then holds the response until it is taken. Even with a receiver
// that is always ready, a new request waits for the capture, execute and
// respond steps of the controller; the word store's read port is registered.
// When the receiver stalls, the response is held stable and no new request
// is accepted until it is taken. Reset empties every queue and zeroes its
// lost-word counter; the word store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module multi_queue_fifo_bank (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: write_word[31:0].
    input  wire  [31:0] s_tdata,
    // Fields from bit 0: opcode[1:0], queue_index[4:2].
    input  wire  [4:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // Fields from bit 0: read_word[31:0], lost_words[63:32].
    output logic [63:0] m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [1:0]  m_tuser
);

    mqfb_pkg::t_ctrl_cmd                cmd;
    logic [mqfb_pkg::DATA_W-1:0]        read_word;
    logic [mqfb_pkg::STATUS_W-1:0]      status;
    logic [mqfb_pkg::LOST_W-1:0]        lost_words;

    mqfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_cmd      (cmd)
    );

    mqfb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (s_tuser[1:0]),
        .i_queue_index (s_tuser[4:2]),
        .i_write_word  (s_tdata),
        .o_read_word   (read_word),
        .o_status      (status),
        .o_lost_words  (lost_words)
    );

    assign m_tdata = {lost_words, read_word};
    assign m_tuser = status;

endmodule
`default_nettype wire
